@@ rtl/twbp_pkg.sv @@
package twbp_pkg;

  localparam int unsigned MaskW  = 32;
  localparam int unsigned PhaseW = 5;
  localparam int unsigned OutW   = 8;

  // Mask classes that skip the run search.
  typedef struct packed {
    logic none;
    logic full;
  } twbp_kind_t;

endpackage

@@ rtl/twbp_front.sv @@
module twbp_front
  import twbp_pkg::*;
#(
  parameter int unsigned PHASE_COUNT = 32,
  localparam int unsigned IdxW = $clog2(PHASE_COUNT)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [MaskW-1:0]       mask_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [PHASE_COUNT-1:0] mask_o,
  output logic [IdxW-1:0]        start_o,
  output twbp_kind_t             kind_o
);

  logic [PHASE_COUNT-1:0] m;
  logic [PHASE_COUNT-1:0] rise;
  logic [PHASE_COUNT-1:0] low;
  logic [IdxW-1:0]        start;
  logic                   valid_q;
  logic [PHASE_COUNT-1:0] mask_q;
  logic [IdxW-1:0]        start_q;
  twbp_kind_t             kind_q;

  always_comb begin
    m = '0;
    for (int j = 0; j < PHASE_COUNT; j++) begin
      if (j < MaskW) begin
        m[j] = mask_i[j];
      end
    end
  end

  // A rising edge is a set bit whose lower circular neighbor is clear.
  assign rise = m & ~{m[PHASE_COUNT-2:0], m[PHASE_COUNT-1]};
  assign low  = rise & (~rise + PHASE_COUNT'(1));

  always_comb begin
    start = '0;
    for (int j = 0; j < PHASE_COUNT; j++) begin
      if (low[j]) begin
        start = start | IdxW'(j);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mask_q      <= m;
      start_q     <= start;
      kind_q.none <= (m == '0);
      kind_q.full <= (m == '1);
    end
  end

  assign valid_o = valid_q;
  assign mask_o  = mask_q;
  assign start_o = start_q;
  assign kind_o  = kind_q;

endmodule

@@ rtl/twbp_cell.sv @@
module twbp_cell
  import twbp_pkg::*;
#(
  parameter int unsigned PHASE_COUNT = 32,
  parameter int unsigned CELL_IDX    = 0,
  localparam int unsigned IdxW = $clog2(PHASE_COUNT),
  localparam int unsigned LenW = $clog2(PHASE_COUNT + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [PHASE_COUNT-1:0] mask_i,
  input  logic [IdxW-1:0]        start_i,
  input  twbp_kind_t             kind_i,
  input  logic [LenW-1:0]        len_i,
  input  logic [IdxW-1:0]        open_at_i,
  input  logic [LenW-1:0]        top_len_i,
  input  logic [IdxW-1:0]        top_at_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [PHASE_COUNT-1:0] mask_o,
  output logic [IdxW-1:0]        start_o,
  output twbp_kind_t             kind_o,
  output logic [LenW-1:0]        len_o,
  output logic [IdxW-1:0]        open_at_o,
  output logic [LenW-1:0]        top_len_o,
  output logic [IdxW-1:0]        top_at_o
);

  logic                   valid_q;
  logic [PHASE_COUNT-1:0] mask_q;
  logic [IdxW-1:0]        start_q;
  twbp_kind_t             kind_q;
  logic [LenW-1:0]        len_q, len_d;
  logic [IdxW-1:0]        open_at_q, open_at_d;
  logic [LenW-1:0]        top_len_q, top_len_d;
  logic [IdxW-1:0]        top_at_q, top_at_d;

  always_comb begin
    len_d     = '0;
    open_at_d = open_at_i;
    top_len_d = top_len_i;
    top_at_d  = top_at_i;
    if (mask_i[0]) begin
      len_d = len_i + LenW'(1);
      if (len_i == '0) begin
        open_at_d = IdxW'(CELL_IDX);
      end
      if (len_d > top_len_i) begin
        top_len_d = len_d;
        top_at_d  = open_at_d;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mask_q    <= mask_i >> 1;
      start_q   <= start_i;
      kind_q    <= kind_i;
      len_q     <= len_d;
      open_at_q <= open_at_d;
      top_len_q <= top_len_d;
      top_at_q  <= top_at_d;
    end
  end

  assign valid_o   = valid_q;
  assign mask_o    = mask_q;
  assign start_o   = start_q;
  assign kind_o    = kind_q;
  assign len_o     = len_q;
  assign open_at_o = open_at_q;
  assign top_len_o = top_len_q;
  assign top_at_o  = top_at_q;

  a_len_le_best : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !kind_q.none && !kind_q.full |-> len_q <= top_len_q)
    else $error("current run longer than best run");

  a_best_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !kind_q.none && !kind_q.full |->
      int'(top_at_q) + int'(top_len_q) <= CELL_IDX + 1)
    else $error("best run reaches past scanned phases");

  a_run_ends_here : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !kind_q.none && !kind_q.full && len_q != '0 |->
      int'(open_at_q) + int'(len_q) == CELL_IDX + 1)
    else $error("open run does not end at this cell");

endmodule

@@ rtl/twbp_back.sv @@
module twbp_back
  import twbp_pkg::*;
#(
  parameter int unsigned PHASE_COUNT = 32,
  localparam int unsigned IdxW = $clog2(PHASE_COUNT),
  localparam int unsigned LenW = $clog2(PHASE_COUNT + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [PHASE_COUNT-1:0] mask_i,
  input  logic [IdxW-1:0]        start_i,
  input  twbp_kind_t             kind_i,
  input  logic [LenW-1:0]        top_len_i,
  input  logic [IdxW-1:0]        top_at_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [PhaseW-1:0]      best_phase_o,
  output logic                   found_o
);

  localparam logic [IdxW+1:0] N1 = (IdxW + 2)'(PHASE_COUNT);
  localparam logic [IdxW+1:0] N2 = (IdxW + 2)'(2 * PHASE_COUNT);

  logic [IdxW+1:0]   sum;
  logic [IdxW+1:0]   wrapped;
  logic [IdxW-1:0]   phase;
  logic [IdxW+PhaseW:0] phase_ext;
  logic              valid_q;
  logic [PhaseW-1:0] best_phase_q;
  logic              found_q;

  assign sum = (IdxW + 2)'(start_i) + (IdxW + 2)'(top_at_i)
             + (IdxW + 2)'(top_len_i >> 1);

  always_comb begin
    if (sum >= N2) begin
      wrapped = sum - N2;
    end else if (sum >= N1) begin
      wrapped = sum - N1;
    end else begin
      wrapped = sum;
    end
    priority if (kind_i.none) begin
      phase = '0;
    end else if (kind_i.full) begin
      phase = IdxW'(PHASE_COUNT / 2);
    end else begin
      phase = wrapped[IdxW-1:0];
    end
  end

  assign phase_ext = (IdxW + PhaseW + 1)'(phase);
  assign ready_o   = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      best_phase_q <= phase_ext[PhaseW-1:0];
      found_q      <= !kind_i.none;
    end
  end

  assign valid_o      = valid_q;
  assign best_phase_o = best_phase_q;
  assign found_o      = found_q;

  a_mask_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> mask_i == '0)
    else $error("mask not fully consumed by the cell chain");

  a_kind_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !(kind_i.none && kind_i.full))
    else $error("mask flagged both empty and full");

  a_run_present : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !kind_i.none && !kind_i.full |-> top_len_i != '0)
    else $error("partial mask without a passing run");

endmodule

@@ rtl/tuning_window_best_phase.sv @@
// Channel  Dir  Word contents (lowest bit first)
// s_axis   in   tdata[31:0] pass_mask
// m_axis   out  tdata[4:0] best_phase, tdata[7:5] zero; tuser[0] found
//
// One word is accepted per cycle while m_axis is not stalled; each word passes the front
// register, the row of PHASE_COUNT scan cells (one phase per cell) and the back register.
// Reset clears the valid flags of every stage; data registers are not reset.
// Each stage holds its word while the stage after it is full and stalled,
// so input is taken as long as any stage ahead has room.
module tuning_window_best_phase
  import twbp_pkg::*;
#(
  parameter int unsigned PHASE_COUNT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [MaskW-1:0]  s_axis_tdata,   // pass_mask
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OutW-1:0]   m_axis_tdata,   // best_phase, zero pad
  output logic              m_axis_tuser    // found
);

  localparam int unsigned IdxW = $clog2(PHASE_COUNT);
  localparam int unsigned LenW = $clog2(PHASE_COUNT + 1);

  logic                   f_valid, f_ready;
  logic [PHASE_COUNT-1:0] f_mask, rot_mask;
  logic [IdxW-1:0]        f_start;
  logic [IdxW:0]          rot_left;
  twbp_kind_t             f_kind;

  logic                   c_valid [0:PHASE_COUNT];
  logic                   c_ready [0:PHASE_COUNT];
  logic [PHASE_COUNT-1:0] c_mask [0:PHASE_COUNT];
  logic [IdxW-1:0]        c_start [0:PHASE_COUNT];
  twbp_kind_t             c_kind [0:PHASE_COUNT];
  logic [LenW-1:0]        c_len [0:PHASE_COUNT];
  logic [IdxW-1:0]        c_open_at [0:PHASE_COUNT];
  logic [LenW-1:0]        c_top_len [0:PHASE_COUNT];
  logic [IdxW-1:0]        c_top_at [0:PHASE_COUNT];

  logic [PhaseW-1:0]      best_phase;
  logic                   found;

  twbp_front #(.PHASE_COUNT(PHASE_COUNT)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .mask_i  (s_axis_tdata),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .mask_o  (f_mask),
    .start_o (f_start),
    .kind_o  (f_kind)
  );

  // Rotate so the scan begins at the first rising edge.
  assign rot_left = (IdxW + 1)'(PHASE_COUNT) - (IdxW + 1)'(f_start);
  assign rot_mask = (f_mask >> f_start) | (f_mask << rot_left);

  assign c_valid[0]   = f_valid;
  assign f_ready      = c_ready[0];
  assign c_mask[0]    = rot_mask;
  assign c_start[0]   = f_start;
  assign c_kind[0]    = f_kind;
  assign c_len[0]     = '0;
  assign c_open_at[0] = '0;
  assign c_top_len[0] = '0;
  assign c_top_at[0]  = '0;

  for (genvar k = 0; k < PHASE_COUNT; k++) begin : g_cell
    twbp_cell #(
      .PHASE_COUNT (PHASE_COUNT),
      .CELL_IDX    (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (c_valid[k]),
      .ready_o   (c_ready[k]),
      .mask_i    (c_mask[k]),
      .start_i   (c_start[k]),
      .kind_i    (c_kind[k]),
      .len_i     (c_len[k]),
      .open_at_i (c_open_at[k]),
      .top_len_i (c_top_len[k]),
      .top_at_i  (c_top_at[k]),
      .valid_o   (c_valid[k+1]),
      .ready_i   (c_ready[k+1]),
      .mask_o    (c_mask[k+1]),
      .start_o   (c_start[k+1]),
      .kind_o    (c_kind[k+1]),
      .len_o     (c_len[k+1]),
      .open_at_o (c_open_at[k+1]),
      .top_len_o (c_top_len[k+1]),
      .top_at_o  (c_top_at[k+1])
    );
  end

  twbp_back #(.PHASE_COUNT(PHASE_COUNT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (c_valid[PHASE_COUNT]),
    .ready_o      (c_ready[PHASE_COUNT]),
    .mask_i       (c_mask[PHASE_COUNT]),
    .start_i      (c_start[PHASE_COUNT]),
    .kind_i       (c_kind[PHASE_COUNT]),
    .top_len_i    (c_top_len[PHASE_COUNT]),
    .top_at_i     (c_top_at[PHASE_COUNT]),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .best_phase_o (best_phase),
    .found_o      (found)
  );

  assign m_axis_tdata = OutW'(best_phase);
  assign m_axis_tuser = found;

endmodule
